@@ rtl/core/rbia_pkg.sv @@
// Shared types and constants for the region bitmap index allocator.
// Used by rbia_ctrl, rbia_dp and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbia_pkg;

    localparam int REGION_SIZE   = 1024;
    localparam int REGION_COUNT  = 3;
    localparam int WORD_BITS     = 32;

    localparam int TOTAL_ENTRIES = REGION_SIZE * REGION_COUNT;
    localparam int MAP_WORDS     = (TOTAL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int REGION_WORDS  = REGION_SIZE / WORD_BITS;

    localparam int OP_W    = 2;
    localparam int REG_W   = 2;
    localparam int IDX_W   = 12;
    localparam int ST_W    = 2;

    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int WADDR_W = $clog2(MAP_WORDS);
    localparam int ROFF_W  = (REGION_WORDS > 1) ? $clog2(REGION_WORDS) : 1;
    localparam int BND_W   = $clog2(TOTAL_ENTRIES) + 1;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - ST_W;

    typedef enum logic [OP_W-1:0] {
        OP_FIND    = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_IN_USE    = 2'd2,
        ST_OUTSIDE   = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    latch_req;
        logic    scan_start;
        logic    scan_next;
        logic    rmw_read;
        logic    map_write;
        logic    res_load;
        logic    res_use_found;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic region_ok;
        logic in_region;
        logic word_has_free;
        logic scan_last;
        logic bit_used;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/core/region_bitmap_index_allocator.sv @@
// Region bitmap index allocator: usage bitmap split into equal regions with
// first-fit find, claim and release. Uses rbia_pkg, rbia_ctrl and rbia_dp.
//
// Usage:
//   Request channel (s_t*): one beat per request with opcode, region and
//   absolute entry index. Result channel (m_t*): exactly one beat per
//   request with found index and status, in request order.
//   Requests are handled one at a time. Claim and release pass from accept
//   to result valid through decode and map read, check/write, and output.
//   Find reads one 32-bit map word per cycle from the map memory and stops
//   at the first word with a clear bit, or after the last word of the
//   region when the region is full with no free entry.
//   Rejected requests (bad region, index outside region, unused opcode)
//   answer from decode without a map access. The next request is taken
//   only once the result has been loaded into the output register.
//   Reset clears the per-word valid bits, so the whole map reads as free at
//   once; there is no clearing pass. A stalled result sits in the output
//   register; the next request is still taken and worked on, and its
//   result waits for the output register to empty.
`timescale 1ns / 1ps
`default_nettype none

module region_bitmap_index_allocator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [1:0] opcode, [3:2] region, [15:4] entry_index
    input  wire logic [rbia_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [11:0] found_index, [13:12] status, [15:14] zero
    output logic [rbia_pkg::OUT_TDATA_W-1:0]       o_m_tdata
);
    import rbia_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rbia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    rbia_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_req_tdata (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/rbia_ctrl.sv @@
// Controller state machine for the region bitmap index allocator.
// Depends on rbia_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module rbia_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire rbia_pkg::t_dp_stat i_stat,
    output rbia_pkg::t_dp_cmd      o_cmd
);
    import rbia_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_RMW    = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_NONE) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_FINISH;
                end else if (!i_stat.region_ok) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OUTSIDE;
                    n_state          = S_FINISH;
                end else if (i_stat.op == OP_FIND) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (!i_stat.in_region) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OUTSIDE;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.rmw_read = 1'b1;
                    n_state        = S_RMW;
                end
            end
            S_SCAN: begin
                // one map word checked per cycle, next word read in parallel
                if (i_stat.word_has_free) begin
                    o_cmd.res_load      = 1'b1;
                    o_cmd.res_use_found = 1'b1;
                    o_cmd.res_status    = ST_OK;
                    n_state             = S_FINISH;
                end else if (i_stat.scan_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NONE_FREE;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_RMW: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.op == OP_CLAIM && i_stat.bit_used) begin
                    o_cmd.res_status = ST_IN_USE;
                end else begin
                    o_cmd.map_write  = 1'b1;
                    o_cmd.res_status = ST_OK;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/rbia_dp.sv @@
// Datapath for the region bitmap index allocator: request registers, usage
// map memory with per-word valid bits, scan logic and output register.
// Depends on rbia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbia_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rbia_pkg::t_dp_cmd                 i_cmd,
    output rbia_pkg::t_dp_stat                     o_stat,
    input  wire logic [rbia_pkg::IN_TDATA_W-1:0]   i_req_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [rbia_pkg::OUT_TDATA_W-1:0]       o_m_tdata
);
    import rbia_pkg::*;

    // request
    t_op               r_op;
    logic [REG_W-1:0]  r_region;
    logic [IDX_W-1:0]  r_idx;

    // usage map
    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    // scan position: word held in r_rd_data and its offset within the region
    logic [WADDR_W-1:0] r_scan_word;
    logic [ROFF_W-1:0]  r_scan_off;

    // result and output register
    logic [IDX_W-1:0]   r_res_found;
    t_status            r_res_status;
    logic               r_m_tvalid;
    logic [IDX_W-1:0]   r_m_found;
    t_status            r_m_status;

    logic [BND_W-1:0]     lo_bound;
    logic [BND_W-1:0]     hi_bound;
    logic [BND_W-1:0]     idx_ext;
    logic [WADDR_W-1:0]   req_word;
    logic [BIT_W-1:0]     bit_sel;
    logic [WADDR_W-1:0]   start_word;
    logic [WORD_BITS-1:0] word_cur;
    logic [WORD_BITS-1:0] zero_oh;
    logic [BIT_W-1:0]     zero_pos;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic [IDX_W-1:0]     found_idx;

    assign lo_bound   = BND_W'(r_region) * BND_W'(REGION_SIZE);
    assign hi_bound   = lo_bound + BND_W'(REGION_SIZE);
    assign idx_ext    = BND_W'(r_idx);
    assign req_word   = WADDR_W'(r_idx[IDX_W-1:BIT_W]);
    assign bit_sel    = r_idx[BIT_W-1:0];
    assign start_word = WADDR_W'(int'(r_region) * REGION_WORDS);

    // a word never written reads as all free
    assign word_cur = r_rd_vld ? r_rd_data : '0;

    // isolate lowest clear bit, then encode it
    assign zero_oh = ~word_cur & (word_cur + WORD_BITS'(1));

    always_comb begin
        zero_pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (zero_oh[b]) begin
                zero_pos = zero_pos | BIT_W'(b);
            end
        end
    end

    assign found_idx = IDX_W'({r_scan_word, zero_pos});
    assign bit_mask  = WORD_BITS'(1) << bit_sel;
    assign wr_data   = (r_op == OP_CLAIM) ? (word_cur | bit_mask) : (word_cur & ~bit_mask);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = req_word;
        if (i_cmd.scan_start) begin
            rd_en   = 1'b1;
            rd_addr = start_word;
        end else if (i_cmd.scan_next) begin
            rd_en   = 1'b1;
            rd_addr = r_scan_word + WADDR_W'(1);
        end else if (i_cmd.rmw_read) begin
            rd_en   = 1'b1;
            rd_addr = req_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_op     <= t_op'(i_req_tdata[OP_W-1:0]);
            r_region <= i_req_tdata[OP_W +: REG_W];
            r_idx    <= i_req_tdata[OP_W+REG_W +: IDX_W];
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.map_write) begin
            r_mem[req_word] <= wr_data;
        end
        if (i_cmd.scan_start) begin
            r_scan_word <= start_word;
            r_scan_off  <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan_word <= r_scan_word + WADDR_W'(1);
            r_scan_off  <= r_scan_off + ROFF_W'(1);
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_found  <= i_cmd.res_use_found ? found_idx : '0;
        end
        if (i_cmd.out_load) begin
            r_m_found  <= r_res_found;
            r_m_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (i_cmd.map_write) begin
                r_valid[req_word] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    assign o_stat.op            = r_op;
    assign o_stat.region_ok     = (int'(r_region) < REGION_COUNT);
    assign o_stat.in_region     = (idx_ext >= lo_bound) && (idx_ext < hi_bound);
    assign o_stat.word_has_free = ~&word_cur;
    assign o_stat.scan_last     = (r_scan_off == ROFF_W'(REGION_WORDS - 1));
    assign o_stat.bit_used      = word_cur[bit_sel];
    assign o_stat.out_free      = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_m_status, r_m_found};

endmodule

`default_nettype wire
